// File: src/ptt_pkg.sv
// Shared types and constants of the position-triggered task table.
package ptt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [15:0] BLINK_RESET = 16'd200;
  localparam logic [31:0] TRACK_MAX = 32'd255;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POLL   = 2'd1,
    CMD_REPOS  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LEFT  = 2'd0,
    KIND_RIGHT = 2'd1,
    KIND_TRACK = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_ACCEPTED = 3'd0,
    ACT_FULL     = 3'd1,
    ACT_TOGGLE   = 3'd2,
    ACT_LED_OFF  = 3'd3,
    ACT_TRACK    = 3'd4,
    ACT_DONE     = 3'd5
  } action_t;

  typedef struct packed {
    logic signed [31:0] start;
    logic signed [31:0] stop;
    kind_t              kind;
    logic [31:0]        data;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_LEFT  = 3'd1,
    OP_RIGHT = 3'd2,
    OP_NEW   = 3'd3,
    OP_HEAD  = 3'd4,
    OP_SHIFT = 3'd5
  } cell_op_t;

endpackage

// File: src/ptt_cell.sv
// One table slot: holds an entry, loads from its neighbors, the new entry or the head, or shifts by delta.
module ptt_cell (
  input  logic              clk,
  input  ptt_pkg::cell_op_t op,
  input  ptt_pkg::entry_t   left,
  input  ptt_pkg::entry_t   right,
  input  ptt_pkg::entry_t   fresh,
  input  ptt_pkg::entry_t   head,
  input  logic [31:0]       delta,
  output ptt_pkg::entry_t   q
);

  always_ff @(posedge clk) begin
    case (op)
      ptt_pkg::OP_LEFT:  q <= left;
      ptt_pkg::OP_RIGHT: q <= right;
      ptt_pkg::OP_NEW:   q <= fresh;
      ptt_pkg::OP_HEAD:  q <= head;
      ptt_pkg::OP_SHIFT: begin
        q.start <= q.start + delta;
        q.stop  <= q.stop + delta;
      end
      default: ;
    endcase
  end

endmodule

// File: src/position_triggered_task_table.sv
// Top level: command decode, poll sequencer, result register and config port.
// Insert and unused command: result word in the cycle after acceptance, never busy.
// Reposition: done word from the REPOS state after acceptance. Poll: the walk visits EXAM per
// examined entry, OFF for each entry both toggled and removed, RESTORE for unexamined entries
// when the walk stops early, then DONE issues the done word. Next word accepted with the done word.
// Results cannot be stalled. Synchronous reset empties the table, sets blink_period to 200.
module position_triggered_task_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] position,
  input  logic [31:0] tick,
  input  logic [31:0] task_start,
  input  logic [31:0] task_end,
  input  logic [1:0]  task_kind,
  input  logic [31:0] task_data,
  output logic        result_valid,
  output logic [2:0]  action,
  output logic [1:0]  led_index,
  output logic [7:0]  track_num,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int D = ptt_pkg::TABLE_DEPTH;
  localparam int CW = ptt_pkg::CNT_W;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_EXAM    = 6'b000010,
    ST_OFF     = 6'b000100,
    ST_RESTORE = 6'b001000,
    ST_REPOS   = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   remain;
  logic [31:0]     cur_pos;
  logic [31:0]     poll_pos;
  logic [31:0]     poll_tick;
  logic [31:0]     delta;
  logic [15:0]     blink_period;

  ptt_pkg::entry_t   cells [D];
  ptt_pkg::cell_op_t ops [D];
  ptt_pkg::entry_t   fresh;
  ptt_pkg::entry_t   head_in;
  ptt_pkg::entry_t   upd;

  logic [D-1:0]  recv;
  logic          acc;
  logic [CW-1:0] cnt_m1;
  logic          full;
  logic          ins_go;
  logic          h_before;
  logic          h_blink;
  logic          h_due;
  logic          h_remove;
  logic          do_rot;
  logic          do_drop;
  logic [1:0]    h_led;
  logic [7:0]    h_track;

  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, blink_period};

  assign fresh.start = $signed(task_start);
  assign fresh.stop  = $signed(task_end);
  assign fresh.kind  = ptt_pkg::kind_t'(task_kind);
  assign fresh.data  = task_data;

  assign cnt_m1 = count - 1'b1;
  assign full   = (count >= CW'(D));
  assign ins_go = (state == ST_IDLE) && start
                  && (command == ptt_pkg::CMD_INSERT) && !full;

  assign h_before = $signed(poll_pos) < cells[0].start;
  assign h_blink  = (cells[0].kind == ptt_pkg::KIND_LEFT)
                    || (cells[0].kind == ptt_pkg::KIND_RIGHT);
  assign h_due    = h_blink && (cells[0].data <= poll_tick);
  assign h_remove = !($signed(poll_pos) < cells[0].stop);
  assign h_led    = {1'b1, cells[0].kind[0]};
  assign h_track  = (cells[0].data <= ptt_pkg::TRACK_MAX) ? cells[0].data[7:0] : 8'd0;

  always_comb begin
    upd = cells[0];
    if (h_due) begin
      upd.data = poll_tick + {16'd0, blink_period};
    end
  end

  assign head_in = (state == ST_EXAM) ? upd : cells[0];

  // insertion point: slot j receives when no live entry at or above j starts lower
  always_comb begin
    acc = 1'b0;
    for (int j = D - 1; j >= 0; j--) begin
      acc = acc | ((CW'(j) < count) && (cells[j].start < $signed(task_start)));
      recv[j] = !acc;
    end
  end

  always_comb begin
    do_rot  = 1'b0;
    do_drop = 1'b0;
    case (state)
      ST_EXAM: begin
        if (remain != '0 && !h_before) begin
          if (h_remove) begin
            do_drop = !(h_blink && h_due);
          end else begin
            do_rot = 1'b1;
          end
        end
      end
      ST_OFF:     do_drop = 1'b1;
      ST_RESTORE: do_rot = (remain != '0);
      default: ;
    endcase
  end

  always_comb begin
    for (int j = 0; j < D; j++) begin
      ops[j] = ptt_pkg::OP_HOLD;
      if (ins_go) begin
        if (j > 0 && recv[(j > 0) ? j - 1 : 0] && (CW'(j) - 1'b1 < count)) begin
          ops[j] = ptt_pkg::OP_LEFT;
        end else if (recv[j] && CW'(j) <= count
                     && (j == 0 || !recv[(j > 0) ? j - 1 : 0])) begin
          ops[j] = ptt_pkg::OP_NEW;
        end
      end else if (do_rot || do_drop) begin
        if (CW'(j) < cnt_m1) begin
          ops[j] = ptt_pkg::OP_RIGHT;
        end else if (do_rot && CW'(j) == cnt_m1) begin
          ops[j] = ptt_pkg::OP_HEAD;
        end
      end else if (state == ST_REPOS && CW'(j) < count) begin
        ops[j] = ptt_pkg::OP_SHIFT;
      end
    end
  end

  for (genvar g = 0; g < D; g++) begin : g_cell
    ptt_cell u_cell (
      .clk   (clk),
      .op    (ops[g]),
      .left  (cells[(g > 0) ? g - 1 : 0]),
      .right (cells[(g < D - 1) ? g + 1 : g]),
      .fresh (fresh),
      .head  (head_in),
      .delta (delta),
      .q     (cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period <= ptt_pkg::BLINK_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      blink_period <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      remain       <= '0;
      cur_pos      <= '0;
      result_valid <= 1'b0;
      action       <= ptt_pkg::ACT_DONE;
      led_index    <= 2'd0;
      track_num    <= 8'd0;
      last         <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      led_index    <= 2'd0;
      track_num    <= 8'd0;
      last         <= 1'b0;
      if (do_drop) begin
        count  <= cnt_m1;
      end
      if (do_drop || do_rot) begin
        remain <= remain - 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            case (command)
              ptt_pkg::CMD_INSERT: begin
                result_valid <= 1'b1;
                last         <= 1'b1;
                action       <= full ? ptt_pkg::ACT_FULL : ptt_pkg::ACT_ACCEPTED;
                if (!full) begin
                  count <= count + 1'b1;
                end
              end
              ptt_pkg::CMD_POLL: begin
                cur_pos   <= position;
                poll_pos  <= position;
                poll_tick <= tick;
                remain    <= count;
                state     <= ST_EXAM;
              end
              ptt_pkg::CMD_REPOS: begin
                delta   <= position - cur_pos;
                cur_pos <= position;
                state   <= ST_REPOS;
              end
              default: begin
                result_valid <= 1'b1;
                last         <= 1'b1;
                action       <= ptt_pkg::ACT_DONE;
              end
            endcase
          end
        end
        ST_EXAM: begin
          if (remain == '0) begin
            state <= ST_DONE;
          end else if (h_before) begin
            state <= ST_RESTORE;
          end else begin
            if (h_due) begin
              result_valid <= 1'b1;
              action       <= ptt_pkg::ACT_TOGGLE;
              led_index    <= h_led;
            end else if (cells[0].kind == ptt_pkg::KIND_TRACK) begin
              result_valid <= 1'b1;
              action       <= ptt_pkg::ACT_TRACK;
              track_num    <= h_track;
            end else if (h_remove && h_blink) begin
              result_valid <= 1'b1;
              action       <= ptt_pkg::ACT_LED_OFF;
              led_index    <= h_led;
            end
            if (h_remove && h_blink && h_due) begin
              state <= ST_OFF;
            end
          end
        end
        ST_OFF: begin
          result_valid <= 1'b1;
          action       <= ptt_pkg::ACT_LED_OFF;
          led_index    <= h_led;
          state        <= ST_EXAM;
        end
        ST_RESTORE: begin
          if (remain == '0) begin
            state <= ST_DONE;
          end
        end
        ST_REPOS: begin
          result_valid <= 1'b1;
          last         <= 1'b1;
          action       <= ptt_pkg::ACT_DONE;
          state        <= ST_IDLE;
        end
        ST_DONE: begin
          result_valid <= 1'b1;
          last         <= 1'b1;
          action       <= ptt_pkg::ACT_DONE;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
